// File: hw/rtl/vsbl_pkg.sv
// Shared types and constants for the volatility surface lookup block.
`default_nettype none
package vsbl_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic CFG_TENOR_COUNT = 1'b0;
    localparam logic CFG_RATIO_COUNT = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BRACKET = 2'd1;
    localparam logic [1:0] STAT_SAT     = 2'd2;

    typedef enum logic [2:0] {
        OP_QUERY    = 3'd0,
        OP_LD_RATIO = 3'd1,
        OP_LD_TENOR = 3'd2,
        OP_LD_GRID  = 3'd3,
        OP_LD_NONE  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [4:0]         row;
        logic [4:0]         column;
        logic signed [31:0] cell_value;
        logic [30:0]        tenor;
        logic [30:0]        moneyness;
    } t_item;

endpackage
`default_nettype wire

// File: hw/rtl/vsbl_front.sv
// Front end: accepts requests and classifies them into queue items.
`default_nettype none
module vsbl_front import vsbl_pkg::*; #(
    parameter int MAX_TENORS = 16,
    parameter int MAX_RATIOS = 16
) (
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [4:0]         i_row,
    input  wire logic [4:0]         i_column,
    input  wire logic signed [31:0] i_cell_value,
    input  wire logic [30:0]        i_tenor,
    input  wire logic [30:0]        i_moneyness,
    input  wire logic               i_full,
    output logic                    o_push,
    output t_item                   o_item
);
    logic row_ok, col_ok;
    t_op  op;

    assign row_ok = (i_row != 5'd0) && (32'(i_row) <= MAX_TENORS);
    assign col_ok = (i_column != 5'd0) && (32'(i_column) <= MAX_RATIOS);

    always_comb begin
        if (i_kind == KIND_QUERY) begin
            op = OP_QUERY;
        end else if (i_row == 5'd0 && col_ok) begin
            op = OP_LD_RATIO;
        end else if (i_column == 5'd0 && row_ok) begin
            op = OP_LD_TENOR;
        end else if (row_ok && col_ok) begin
            op = OP_LD_GRID;
        end else begin
            op = OP_LD_NONE;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.op         = op;
        o_item.row        = i_row;
        o_item.column     = i_column;
        o_item.cell_value = i_cell_value;
        o_item.tenor      = i_tenor;
        o_item.moneyness  = i_moneyness;
    end
endmodule
`default_nettype wire

// File: hw/rtl/vsbl_fifo.sv
// Short item queue between front end and back end.
`default_nettype none
module vsbl_fifo import vsbl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);
    localparam int PW = $clog2(Q_DEPTH);

    t_item          r_mem [Q_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/vsbl_scan.sv
// Axis store with a serial scan for the bracketing interval.
`default_nettype none
module vsbl_scan #(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic signed [31:0]       i_wdata,
    input  wire logic                     i_start,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_count,
    input  wire logic [30:0]              i_query,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [$clog2(DEPTH)-1:0]      o_idx,
    output logic signed [31:0]            o_lo,
    output logic signed [31:0]            o_hi
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rdata, r_prev, r_first, r_f1, r_lo, r_hi;
    logic [CW-1:0]      r_k, r_dk, r_n, km1;
    logic [AW-1:0]      r_idx;
    logic               r_found, r_busy, r_dv;
    logic [30:0]        r_q;
    logic signed [32:0] qs, prev_s, cur_s, first_s;
    logic               m, lt, gt, last;
    logic signed [31:0] f1sel;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[r_k[AW-1:0]];
    end

    assign qs      = signed'({2'b00, r_q});
    assign prev_s  = {r_prev[31], r_prev};
    assign cur_s   = {r_rdata[31], r_rdata};
    assign first_s = {r_first[31], r_first};
    assign km1     = r_dk - 1'b1;
    assign m       = (r_dk != '0) && (qs >= prev_s) && (qs <= cur_s);
    assign lt      = qs < first_s;
    assign gt      = qs > cur_s;
    assign last    = (r_dk == r_n - 1'b1);
    assign f1sel   = (r_dk == CW'(1)) ? r_rdata : r_f1;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_count;
            r_q <= i_query;
        end
        if (r_dv) begin
            r_prev <= r_rdata;
            if (r_dk == '0) begin
                r_first <= r_rdata;
            end
            if (r_dk == CW'(1)) begin
                r_f1 <= r_rdata;
            end
            if (m) begin
                r_idx <= km1[AW-1:0];
                r_lo  <= r_prev;
                r_hi  <= r_rdata;
            end
            // above the axis beats below it, which beats any match
            if (last) begin
                if (gt) begin
                    o_idx <= km1[AW-1:0];
                    o_lo  <= r_prev;
                    o_hi  <= r_rdata;
                end else if (lt) begin
                    o_idx <= '0;
                    o_lo  <= r_first;
                    o_hi  <= f1sel;
                end else if (m) begin
                    o_idx <= km1[AW-1:0];
                    o_lo  <= r_prev;
                    o_hi  <= r_rdata;
                end else begin
                    o_idx <= r_idx;
                    o_lo  <= r_lo;
                    o_hi  <= r_hi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_dv    <= 1'b0;
            r_k     <= '0;
            r_dk    <= '0;
            r_found <= 1'b0;
            o_done  <= 1'b0;
            o_ok    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_k     <= '0;
                r_dv    <= 1'b0;
                r_found <= 1'b0;
            end else if (r_busy) begin
                if (r_k != r_n) begin
                    r_k  <= r_k + 1'b1;
                    r_dk <= r_k;
                    r_dv <= 1'b1;
                end else begin
                    r_dv <= 1'b0;
                end
                if (r_dv) begin
                    if (m) begin
                        r_found <= 1'b1;
                    end
                    if (last) begin
                        o_ok   <= gt || lt || m || r_found;
                        o_done <= 1'b1;
                        r_busy <= 1'b0;
                        r_dv   <= 1'b0;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/vsbl_lerp.sv
// One linear interpolation step: multiply, serial divide, saturate.
`default_nettype none
module vsbl_lerp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_v0,
    input  wire logic signed [31:0] i_v1,
    input  wire logic signed [32:0] i_num,
    input  wire logic [31:0]        i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_res,
    output logic                    o_sat
);
    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_MUL  = 5'b00010,
        L_PRE  = 5'b00100,
        L_DIV  = 5'b01000,
        L_FIN  = 5'b10000
    } t_lstate;

    localparam logic [34:0]        Q_LIMIT = 35'h4_0000_0000;
    localparam logic signed [36:0] R_MAX   = 37'sh0_7FFF_FFFF;
    localparam logic signed [36:0] R_MIN   = -37'sh0_8000_0000;

    t_lstate            r_st;
    logic [31:0]        r_an, r_ad, r_den, r_rem, rem_n;
    logic               r_neg, r_ovf, ge;
    logic signed [31:0] r_v0;
    logic [63:0]        r_prod;
    logic [34:0]        r_sh, r_quo;
    logic [5:0]         r_cnt;
    logic signed [32:0] diff, num_abs, diff_abs;
    logic [32:0]        t, t_sub;
    logic signed [36:0] v0e, qe, sum;

    assign diff     = {i_v1[31], i_v1} - {i_v0[31], i_v0};
    assign num_abs  = i_num[32] ? -i_num : i_num;
    assign diff_abs = diff[32] ? -diff : diff;

    assign t     = {r_rem, r_sh[34]};
    assign t_sub = t - {1'b0, r_den};
    assign ge    = t >= {1'b0, r_den};
    assign rem_n = ge ? t_sub[31:0] : t[31:0];

    assign v0e = {{5{r_v0[31]}}, r_v0};
    assign qe  = signed'({2'b00, r_quo});
    assign sum = r_neg ? v0e - qe : v0e + qe;

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            L_IDLE: begin
                if (i_start) begin
                    r_an  <= num_abs[31:0];
                    r_ad  <= diff_abs[31:0];
                    r_neg <= i_num[32] ^ diff[32];
                    r_v0  <= i_v0;
                    r_den <= i_den;
                end
            end
            L_MUL: r_prod <= r_an * r_ad;
            L_PRE: begin
                r_ovf <= {3'b000, r_prod[63:35]} >= r_den;
                r_rem <= {3'b000, r_prod[63:35]};
                r_sh  <= r_prod[34:0];
                r_quo <= '0;
            end
            L_DIV: begin
                r_rem <= rem_n;
                r_sh  <= {r_sh[33:0], 1'b0};
                r_quo <= {r_quo[33:0], ge};
            end
            L_FIN: begin
                if (r_ovf || r_quo > Q_LIMIT) begin
                    o_res <= r_neg ? R_MIN[31:0] : R_MAX[31:0];
                    o_sat <= 1'b1;
                end else if (sum > R_MAX) begin
                    o_res <= R_MAX[31:0];
                    o_sat <= 1'b1;
                end else if (sum < R_MIN) begin
                    o_res <= R_MIN[31:0];
                    o_sat <= 1'b1;
                end else begin
                    o_res <= sum[31:0];
                    o_sat <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_st)
                L_IDLE: if (i_start) r_st <= L_MUL;
                L_MUL:  r_st <= L_PRE;
                L_PRE: begin
                    r_cnt <= '0;
                    r_st  <= L_DIV;
                end
                L_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd34) begin
                        r_st <= L_FIN;
                    end
                end
                L_FIN: begin
                    o_done <= 1'b1;
                    r_st   <= L_IDLE;
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/vsbl_back.sv
// Back end: surface stores, query sequencing and the result register.
`default_nettype none
module vsbl_back import vsbl_pkg::*; #(
    parameter int MAX_TENORS = 16,
    parameter int MAX_RATIOS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [4:0]         i_tenor_count,
    input  wire logic [4:0]         i_ratio_count,
    input  wire logic               i_q_valid,
    input  wire t_item              i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_volatility,
    output logic [1:0]              o_status
);
    localparam int TAW = $clog2(MAX_TENORS);
    localparam int RAW = $clog2(MAX_RATIOS);
    localparam int TCW = $clog2(MAX_TENORS+1);
    localparam int RCW = $clog2(MAX_RATIOS+1);
    localparam int GD  = MAX_TENORS * MAX_RATIOS;
    localparam int GAW = $clog2(GD);
    localparam logic [GAW-1:0] RSTRIDE = GAW'(MAX_RATIOS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_GRID = 8'b0000_1000,
        S_L1   = 8'b0001_0000,
        S_L2   = 8'b0010_0000,
        S_L3   = 8'b0100_0000,
        S_RES  = 8'b1000_0000
    } t_bstate;

    t_bstate            r_st;
    logic               out_free, take, is_query, res_load;
    logic [4:0]         rowm1, colm1;
    logic [TCW-1:0]     nt;
    logic [RCW-1:0]     nr;
    logic [30:0]        r_x, r_y;
    logic               r_rdone, r_tdone, r_sat, r_lstart;
    logic               rs_done, rs_ok, ts_done, ts_ok;
    logic [RAW-1:0]     rs_idx, ci;
    logic [TAW-1:0]     ts_idx, cj;
    logic signed [31:0] rs_lo, rs_hi, ts_lo, ts_hi;
    logic signed [32:0] dx, dy, nx, ny;
    logic signed [31:0] grid [GD];
    logic signed [31:0] r_gdata, r_r1, r_vol;
    logic signed [31:0] r_g [4];
    logic [2:0]         r_gk;
    logic [GAW-1:0]     g_waddr, g_raddr;
    logic               g_we;
    logic               l_done, l_sat;
    logic signed [31:0] l_res, l_v0, l_v1;
    logic signed [32:0] l_num;
    logic [31:0]        l_den;
    logic [1:0]         r_stat;

    always_comb begin
        if (i_tenor_count < 5'd2) begin
            nt = TCW'(2);
        end else if (32'(i_tenor_count) > MAX_TENORS) begin
            nt = TCW'(MAX_TENORS);
        end else begin
            nt = TCW'(i_tenor_count);
        end
        if (i_ratio_count < 5'd2) begin
            nr = RCW'(2);
        end else if (32'(i_ratio_count) > MAX_RATIOS) begin
            nr = RCW'(MAX_RATIOS);
        end else begin
            nr = RCW'(i_ratio_count);
        end
    end

    assign out_free = !o_valid || i_ready;
    assign take     = (r_st == S_IDLE) && i_q_valid && out_free;
    assign o_q_pop  = take;
    assign is_query = (i_q_item.op == OP_QUERY);
    assign rowm1    = i_q_item.row - 5'd1;
    assign colm1    = i_q_item.column - 5'd1;
    assign res_load = (take && !is_query) || (r_st == S_RES && out_free);

    vsbl_scan #(.DEPTH(MAX_RATIOS)) u_rscan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (take && i_q_item.op == OP_LD_RATIO),
        .i_waddr (RAW'(colm1)),
        .i_wdata (i_q_item.cell_value),
        .i_start (take && is_query),
        .i_count (nr),
        .i_query (i_q_item.moneyness),
        .o_done  (rs_done),
        .o_ok    (rs_ok),
        .o_idx   (rs_idx),
        .o_lo    (rs_lo),
        .o_hi    (rs_hi)
    );

    vsbl_scan #(.DEPTH(MAX_TENORS)) u_tscan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (take && i_q_item.op == OP_LD_TENOR),
        .i_waddr (TAW'(rowm1)),
        .i_wdata (i_q_item.cell_value),
        .i_start (take && is_query),
        .i_count (nt),
        .i_query (i_q_item.tenor),
        .o_done  (ts_done),
        .o_ok    (ts_ok),
        .o_idx   (ts_idx),
        .o_lo    (ts_lo),
        .o_hi    (ts_hi)
    );

    // grid corners: bit 0 steps the ratio index, bit 1 the tenor index
    assign ci      = rs_idx + RAW'(r_gk[0]);
    assign cj      = ts_idx + TAW'(r_gk[1]);
    assign g_raddr = GAW'(cj) * RSTRIDE + GAW'(ci);
    assign g_waddr = GAW'(rowm1) * RSTRIDE + GAW'(colm1);
    assign g_we    = take && i_q_item.op == OP_LD_GRID;

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid[g_waddr] <= i_q_item.cell_value;
        end
        r_gdata <= grid[g_raddr];
    end

    assign dx = {rs_hi[31], rs_hi} - {rs_lo[31], rs_lo};
    assign dy = {ts_hi[31], ts_hi} - {ts_lo[31], ts_lo};
    assign nx = signed'({2'b00, r_x}) - {rs_lo[31], rs_lo};
    assign ny = signed'({2'b00, r_y}) - {ts_lo[31], ts_lo};

    always_comb begin
        l_v0  = r_g[0];
        l_v1  = r_g[1];
        l_num = nx;
        l_den = dx[31:0];
        case (r_st)
            S_L2: begin
                l_v0 = r_g[2];
                l_v1 = r_g[3];
            end
            S_L3: begin
                l_v0  = r_r1;
                l_v1  = l_res;
                l_num = ny;
                l_den = dy[31:0];
            end
            default: ;
        endcase
    end

    vsbl_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lstart),
        .i_v0    (l_v0),
        .i_v1    (l_v1),
        .i_num   (l_num),
        .i_den   (l_den),
        .o_done  (l_done),
        .o_res   (l_res),
        .o_sat   (l_sat)
    );

    // second row result is held in the lerp output while the tenor step starts
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x <= i_q_item.moneyness;
            r_y <= i_q_item.tenor;
        end
        if (r_st == S_GRID && r_gk != 3'd0) begin
            r_g[r_gk[1:0] - 2'd1] <= r_gdata;
        end
        if (r_st == S_L1 && l_done) begin
            r_r1 <= l_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_rdone  <= 1'b0;
            r_tdone  <= 1'b0;
            r_sat    <= 1'b0;
            r_lstart <= 1'b0;
            r_gk     <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_lstart <= 1'b0;
            o_valid  <= res_load || (o_valid && !i_ready);
            unique case (r_st)
                S_IDLE: begin
                    if (take) begin
                        if (is_query) begin
                            r_rdone <= 1'b0;
                            r_tdone <= 1'b0;
                            r_sat   <= 1'b0;
                            r_st    <= S_SCAN;
                        end else begin
                            o_volatility <= '0;
                            o_status     <= STAT_OK;
                        end
                    end
                end
                S_SCAN: begin
                    if (rs_done) r_rdone <= 1'b1;
                    if (ts_done) r_tdone <= 1'b1;
                    if ((rs_done || r_rdone) && (ts_done || r_tdone)) begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!rs_ok || !ts_ok || dx[32] || dx == '0 || dy[32] || dy == '0) begin
                        r_vol  <= '0;
                        r_stat <= STAT_BRACKET;
                        r_st   <= S_RES;
                    end else begin
                        r_gk <= '0;
                        r_st <= S_GRID;
                    end
                end
                S_GRID: begin
                    r_gk <= r_gk + 1'b1;
                    if (r_gk == 3'd4) begin
                        r_lstart <= 1'b1;
                        r_st     <= S_L1;
                    end
                end
                S_L1: begin
                    if (l_done) begin
                        r_sat    <= r_sat | l_sat;
                        r_lstart <= 1'b1;
                        r_st     <= S_L2;
                    end
                end
                S_L2: begin
                    if (l_done) begin
                        r_sat    <= r_sat | l_sat;
                        r_lstart <= 1'b1;
                        r_st     <= S_L3;
                    end
                end
                S_L3: begin
                    if (l_done) begin
                        r_vol  <= l_res;
                        r_stat <= (r_sat || l_sat) ? STAT_SAT : STAT_OK;
                        r_st   <= S_RES;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        o_volatility <= r_vol;
                        o_status     <= r_stat;
                        r_st         <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/vol_surface_bilinear_lookup_core.sv
// Top level of the volatility surface bilinear lookup.
//
//  channel  direction  handshake             payload
//  request  in         i_valid / o_ready     i_kind i_row i_column i_cell_value
//                                            i_tenor i_moneyness
//  result   out        o_valid / i_ready     o_volatility o_status
//  config   in         i_cfg_we              i_cfg_idx i_cfg_data
//
// A load is answered once the back end takes it from the queue. A query is answered after
// a serial scan of both axes, four grid reads, then three linear steps on one shared unit
// of a 32x32 multiply and a 35-step restoring divide.
// The request queue holds 4 items and fills while the back end is busy.
// Reset is synchronous; counts return to 2, surface contents are unknown.
`default_nettype none
module vol_surface_bilinear_lookup_core import vsbl_pkg::*; #(
    parameter int MAX_TENORS = 16,
    parameter int MAX_RATIOS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [4:0]         i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [4:0]         i_row,
    input  wire logic [4:0]         i_column,
    input  wire logic signed [31:0] i_cell_value,
    input  wire logic [30:0]        i_tenor,
    input  wire logic [30:0]        i_moneyness,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_volatility,
    output logic [1:0]              o_status
);
    logic [4:0] r_tenor_count, r_ratio_count;
    logic       full, push, q_valid, q_pop;
    t_item      f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenor_count <= 5'd2;
            r_ratio_count <= 5'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TENOR_COUNT: r_tenor_count <= i_cfg_data;
                CFG_RATIO_COUNT: r_ratio_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vsbl_front #(.MAX_TENORS(MAX_TENORS), .MAX_RATIOS(MAX_RATIOS)) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cell_value (i_cell_value),
        .i_tenor      (i_tenor),
        .i_moneyness  (i_moneyness),
        .i_full       (full),
        .o_push       (push),
        .o_item       (f_item)
    );

    vsbl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    vsbl_back #(.MAX_TENORS(MAX_TENORS), .MAX_RATIOS(MAX_RATIOS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tenor_count (r_tenor_count),
        .i_ratio_count (r_ratio_count),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_volatility  (o_volatility),
        .o_status      (o_status)
    );
endmodule
`default_nettype wire

// File: hw/rtl/vsbl_checker.sv
// Port-level checks for the volatility surface lookup, bound to the top level.
`default_nettype none
module vsbl_checker import vsbl_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic signed [31:0] o_volatility,
    input wire logic [1:0]         o_status
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_volatility) && $stable(o_status))
        else $error("stalled result changed");

    a_bracket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_BRACKET |-> o_volatility == '0)
        else $error("bracket failure with nonzero volatility");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == STAT_OK || o_status == STAT_BRACKET || o_status == STAT_SAT)
        else $error("undefined status code");
endmodule

bind vol_surface_bilinear_lookup_core vsbl_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_volatility (o_volatility),
    .o_status     (o_status)
);
`default_nettype wire

// File: tb/vol_surface_bilinear_lookup_core_test.sv
// Testbench for the volatility surface lookup: directed table, then random loads and queries.
`default_nettype none
module vol_surface_bilinear_lookup_core_test;
    import vsbl_pkg::*;

    typedef struct {
        logic        kind;
        logic [4:0]  row;
        logic [4:0]  column;
        logic [31:0] cell_val;
        logic [30:0] tenor;
        logic [30:0] money;
        bit          typed;
        logic [31:0] typed_vol;
        logic [1:0]  typed_stat;
    } req_t;

    typedef struct {
        logic [31:0] vol;
        logic [1:0]  stat;
    } vol_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_TENOR_COUNT;
    logic [4:0]         i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_kind = KIND_LOAD;
    logic [4:0]         i_row = '0;
    logic [4:0]         i_column = '0;
    logic signed [31:0] i_cell_value = '0;
    logic [30:0]        i_tenor = '0;
    logic [30:0]        i_moneyness = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_volatility;
    logic [1:0]         o_status;

    vol_surface_bilinear_lookup_core u_dut (.*);

    always #2 i_clk = ~i_clk;

    // local copy of the surface
    int          tenor_ax[16];
    int          ratio_ax[16];
    int          vol_grid[256];
    logic [4:0]  tenor_cnt;
    logic [4:0]  ratio_cnt;

    vol_result_t expected_vols[$];
    req_t        dir_table[$];
    int          send_idle;
    int          recv_idle;
    int          hold_cycles;
    int          errors;
    int          n_requests;
    int          n_queries;
    int          n_sat;
    int          n_flag;

    function automatic int eff_count(logic [4:0] c);
        return (c < 2) ? 2 : ((c > 16) ? 16 : int'(c));
    endfunction

    function automatic int find_seg(int ax[16], int n, longint q);
        int idx;
        idx = -1;
        for (int k = 0; k + 1 < n; k++)
            if (q >= longint'(ax[k]) && q <= longint'(ax[k + 1]))
                idx = k;
        if (q < longint'(ax[0]))
            idx = 0;
        if (q > longint'(ax[n - 1]))
            idx = n - 2;
        return idx;
    endfunction

    function automatic longint lerp_step(longint v0, longint v1, longint num, longint den,
                                         inout bit sat);
        longint          diff;
        bit              neg;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned dd;
        longint unsigned qq;
        longint          r;
        diff = v1 - v0;
        neg  = (num < 0) != (diff < 0);
        an   = (num < 0) ? -num : num;
        ad   = (diff < 0) ? -diff : diff;
        dd   = den;
        qq   = (an * ad) / dd;
        if (qq > (64'd1 << 34)) begin
            sat = 1'b1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        r = neg ? v0 - longint'(qq) : v0 + longint'(qq);
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic vol_result_t predict_vol(req_t r);
        vol_result_t res;
        int          nt, nr, i, j;
        longint      x, y, x1, x2, y1, y2, r1, r2, v;
        bit          sat;
        res.vol  = '0;
        res.stat = STAT_OK;
        if (r.kind == KIND_LOAD) begin
            if (r.row == 0 && r.column >= 1 && r.column <= 16)
                ratio_ax[r.column - 1] = r.cell_val;
            else if (r.column == 0 && r.row >= 1 && r.row <= 16)
                tenor_ax[r.row - 1] = r.cell_val;
            else if (r.row >= 1 && r.row <= 16 && r.column >= 1 && r.column <= 16)
                vol_grid[(r.row - 1) * 16 + (r.column - 1)] = r.cell_val;
            return res;
        end
        nt = eff_count(tenor_cnt);
        nr = eff_count(ratio_cnt);
        x  = longint'(r.money);
        y  = longint'(r.tenor);
        i  = find_seg(ratio_ax, nr, x);
        j  = find_seg(tenor_ax, nt, y);
        if (i < 0 || j < 0) begin
            res.stat = STAT_BRACKET;
            return res;
        end
        x1 = ratio_ax[i];
        x2 = ratio_ax[i + 1];
        y1 = tenor_ax[j];
        y2 = tenor_ax[j + 1];
        if (x2 - x1 <= 0 || y2 - y1 <= 0) begin
            res.stat = STAT_BRACKET;
            return res;
        end
        sat = 1'b0;
        r1 = lerp_step(vol_grid[j * 16 + i], vol_grid[j * 16 + i + 1], x - x1, x2 - x1, sat);
        r2 = lerp_step(vol_grid[(j + 1) * 16 + i], vol_grid[(j + 1) * 16 + i + 1],
                       x - x1, x2 - x1, sat);
        v  = lerp_step(r1, r2, y - y1, y2 - y1, sat);
        res.vol  = v[31:0];
        res.stat = sat ? STAT_SAT : STAT_OK;
        return res;
    endfunction

    function automatic req_t mk_req(logic kind, int row, int column, logic [31:0] cell_val,
                                    logic [30:0] tenor, logic [30:0] money);
        req_t r;
        r.kind       = kind;
        r.row        = 5'(row);
        r.column     = 5'(column);
        r.cell_val   = cell_val;
        r.tenor      = tenor;
        r.money      = money;
        r.typed      = 1'b0;
        r.typed_vol  = '0;
        r.typed_stat = STAT_OK;
        return r;
    endfunction

    function automatic req_t typed_req(req_t r, logic [31:0] v, logic [1:0] s);
        r.typed      = 1'b1;
        r.typed_vol  = v;
        r.typed_stat = s;
        return r;
    endfunction

    task automatic send_request(req_t r);
        vol_result_t e;
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid      <= 1'b1;
        i_kind       <= r.kind;
        i_row        <= r.row;
        i_column     <= r.column;
        i_cell_value <= r.cell_val;
        i_tenor      <= r.tenor;
        i_moneyness  <= r.money;
        do @(posedge i_clk); while (!o_ready);
        e = predict_vol(r);
        if (r.typed) begin
            e.vol  = r.typed_vol;
            e.stat = r.typed_stat;
        end
        expected_vols.push_back(e);
        n_requests++;
        if (r.kind == KIND_QUERY) begin
            n_queries++;
            if (e.stat == STAT_SAT) n_sat++;
            if (e.stat == STAT_BRACKET) n_flag++;
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        wait (expected_vols.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_counts(logic [4:0] t, logic [4:0] r);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TENOR_COUNT;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RATIO_COUNT;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tenor_cnt = t;
        ratio_cnt = r;
    endtask

    // ascending axes: tenor 0..15 years, ratio 0.5 by 0.25
    task automatic load_axes;
        for (int k = 1; k <= 16; k++) begin
            send_request(mk_req(KIND_LOAD, k, 0, (k - 1) << 16, '0, '0));
            send_request(mk_req(KIND_LOAD, 0, k, 32'h8000 + (k - 1) * 32'h4000, '0, '0));
        end
    endtask

    function automatic req_t rand_req;
        int          p, k;
        logic [31:0] junk;
        req_t        r;
        p    = $urandom_range(99);
        junk = $urandom;
        r = mk_req(KIND_LOAD, $urandom_range(31), $urandom_range(31), junk,
                   31'($urandom), 31'($urandom));
        if (p < 60) begin
            r.kind = KIND_QUERY;
            if ($urandom_range(9) != 0) r.tenor = 31'($urandom_range(32'h110000));
            if ($urandom_range(9) != 0) r.money = 31'($urandom_range(32'h4C000));
        end else if (p < 85) begin
            r.row    = 5'($urandom_range(1, 16));
            r.column = 5'($urandom_range(1, 16));
            if ($urandom_range(4) != 0)
                r.cell_val = $urandom_range(32'h200000) - 32'h100000;
        end else if (p < 93) begin
            k = $urandom_range(1, 16);
            if ($urandom_range(1)) begin
                r.row      = 5'(k);
                r.column   = '0;
                r.cell_val = ((k - 1) << 16) + $urandom_range(16'hFFFF);
            end else begin
                r.row      = '0;
                r.column   = 5'(k);
                r.cell_val = 32'h8000 + (k - 1) * 32'h4000 + $urandom_range(14'h3FFF);
            end
            if ($urandom_range(9) == 0) r.cell_val = $urandom;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        vol_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_vols.size() == 0) begin
                $display("%0t unexpected result: vol %h status %0d", $time,
                         o_volatility, o_status);
                errors++;
            end else begin
                e = expected_vols.pop_front();
                if (o_volatility !== e.vol) begin
                    $display("%0t volatility mismatch: expected %h actual %h", $time,
                             e.vol, o_volatility);
                    errors++;
                end
                if (o_status !== e.stat) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             e.stat, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [4:0] t_cfg[6];
        logic [4:0] r_cfg[6];
        errors      = 0;
        n_requests  = 0;
        n_queries   = 0;
        n_sat       = 0;
        n_flag      = 0;
        hold_cycles = 0;
        send_idle   = 23;
        recv_idle   = 76;
        tenor_cnt   = 2;
        ratio_cnt   = 2;
        foreach (tenor_ax[k]) tenor_ax[k] = 0;
        foreach (ratio_ax[k]) ratio_ax[k] = 0;
        foreach (vol_grid[k]) vol_grid[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every entry written before any query
        load_axes();
        for (int a = 1; a <= 16; a++)
            for (int b = 1; b <= 16; b++)
                send_request(mk_req(KIND_LOAD, a, b,
                                    $urandom_range(32'h100000) - 32'h80000, '0, '0));
        drain();
        set_counts(5'd16, 5'd16);

        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 0, 0, 32'h7FFFFFFF, '1, '1),
                                      '0, STAT_OK));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 17, 3, 32'h1234, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 31, 31, 32'h80000000, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 3, 17, 32'h5555, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 1, 1, 32'h80000000, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 1, 2, 32'h7FFFFFFF, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(mk_req(KIND_QUERY, 31, 31, '1, 31'h0, 31'h8000));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h0, 31'hA000));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h7FFFFFFF, 31'h7FFFFFFF));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h0, 31'h0));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h48000, 31'h2C000));
        // zero width first ratio interval; an exact hit on the shared point takes the later one
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 0, 2, 32'h8000, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h0, 31'h8000));
        dir_table.push_back(typed_req(mk_req(KIND_QUERY, 0, 0, '0, 31'h10000, 31'h0),
                                      '0, STAT_BRACKET));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 0, 2, 32'hC000, '0, '0),
                                      '0, STAT_OK));
        // tenor axis folds back: several intervals hold the first query
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 5, 0, 32'h10000, '0, '0),
                                      '0, STAT_OK));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h20000, 31'h10000));
        dir_table.push_back(mk_req(KIND_QUERY, 0, 0, '0, 31'h40000, 31'h10000));
        dir_table.push_back(typed_req(mk_req(KIND_LOAD, 5, 0, 32'h40000, '0, '0),
                                      '0, STAT_OK));
        foreach (dir_table[k]) send_request(dir_table[k]);
        drain();

        t_cfg = '{5'd0, 5'd16, 5'd31, 5'd2, 5'd16, 5'd0};
        r_cfg = '{5'd1, 5'd16, 5'd17, 5'd16, 5'd2, 5'd0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle = 76;
                recv_idle = 23;
            end else if (ph == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 5) begin
                t_cfg[ph] = 5'($urandom_range(3, 15));
                r_cfg[ph] = 5'($urandom_range(3, 15));
            end
            set_counts(t_cfg[ph], r_cfg[ph]);
            load_axes();
            if (ph == 1) hold_cycles = 600;
            repeat (230) send_request(rand_req());
            drain();
        end

        $display("Covered %0d requests, %0d of them queries (%0d saturated, %0d flagged),",
                 n_requests, n_queries, n_sat, n_flag);
        $display("over six axis count settings with idle, stall and back-pressure phases.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/vsbl_pkg.sv
hw/rtl/vsbl_front.sv
hw/rtl/vsbl_fifo.sv
hw/rtl/vsbl_scan.sv
hw/rtl/vsbl_lerp.sv
hw/rtl/vsbl_back.sv
hw/rtl/vol_surface_bilinear_lookup_core.sv
hw/rtl/vsbl_checker.sv
tb/vol_surface_bilinear_lookup_core_test.sv
